FILE: hw/rtl/unicycle_pose_integrator_unit_defines.svh
// assertion macros used by the pose integrator top level
`ifndef UNICYCLE_POSE_INTEGRATOR_UNIT_DEFINES_SVH
`define UNICYCLE_POSE_INTEGRATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define UPI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define UPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/upi_pkg.sv
// shared types, constants and the arctangent table of the pose integrator
package upi_pkg;

    localparam int ATAN_LEN         = 24;
    localparam int STEP_W           = $clog2(ATAN_LEN);
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CW               = 34;
    localparam int IN_W             = 16;
    localparam int POS_W            = 32;
    localparam int HEAD_W           = 16;
    localparam int PROD_W           = 64;
    localparam int S_DATA_W         = 2 * IN_W;
    localparam int M_DATA_W         = 2 * POS_W + HEAD_W;

    localparam logic [15:0] STEP_TIME_RESET = 16'd655;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] RAD_TO_BAM = 32'sd683565276;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROTATE,
        S_MUL_X,
        S_MUL_Y,
        S_UPDATE,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_VDT,
        MUL_RDT,
        MUL_TURN,
        MUL_PX,
        MUL_PY
    } t_mul_op;

    typedef struct packed {
        logic    load;
        logic    rotate;
        t_mul_op mul_op;
        logic    update;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic              rot_last;
        logic [STEP_W-1:0] step;
        logic              out_free;
    } t_dp_sts;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_val(input logic [STEP_W-1:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/upi_ctrl.sv
// sequencing state machine of the pose integrator
module upi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  upi_pkg::t_dp_sts i_sts,
    output upi_pkg::t_dp_cmd o_cmd
);
    import upi_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ROTATE;
                end
            end
            S_ROTATE: begin
                if (i_sts.rot_last) begin
                    n_state = S_MUL_X;
                end
            end
            S_MUL_X:  n_state = S_MUL_Y;
            S_MUL_Y:  n_state = S_UPDATE;
            S_UPDATE: n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.mul_op = MUL_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_ROTATE: begin
                o_cmd.rotate = 1'b1;
                // scalar products ride along with the first rotations
                if (i_sts.step == STEP_W'(0)) begin
                    o_cmd.mul_op = MUL_VDT;
                end else if (i_sts.step == STEP_W'(1)) begin
                    o_cmd.mul_op = MUL_RDT;
                end else if (i_sts.step == STEP_W'(2)) begin
                    o_cmd.mul_op = MUL_TURN;
                end
            end
            S_MUL_X:  o_cmd.mul_op = MUL_PX;
            S_MUL_Y:  o_cmd.mul_op = MUL_PY;
            S_UPDATE: o_cmd.update = 1'b1;
            S_OUT:    o_cmd.out_load = i_sts.out_free;
            default:  o_cmd.load = 1'b0;
        endcase
    end

endmodule

FILE: hw/rtl/upi_dp.sv
// datapath: cordic rotator, shared multiplier, pose state and output register
module upi_dp #(
    parameter int CORDIC_STEPS = upi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  upi_pkg::t_dp_cmd              i_cmd,
    output upi_pkg::t_dp_sts              o_sts,
    input  logic                          i_cfg_we,
    input  logic [15:0]                   i_cfg_wdata,
    input  logic [upi_pkg::S_DATA_W-1:0]  i_in_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [upi_pkg::M_DATA_W-1:0]  o_out_data
);
    import upi_pkg::*;

    logic [15:0]               r_step_time;
    logic signed [IN_W-1:0]    r_spd;
    logic signed [IN_W-1:0]    r_rate;
    logic signed [CW-1:0]      r_cx;
    logic signed [CW-1:0]      r_cy;
    logic signed [CW-1:0]      r_cz;
    logic                      r_flip;
    logic [STEP_W-1:0]         r_step;
    logic signed [31:0]        r_vdt;
    logic signed [31:0]        r_rdt;
    logic signed [PROD_W-1:0]  r_pturn;
    logic signed [PROD_W-1:0]  r_px;
    logic signed [PROD_W-1:0]  r_py;
    logic signed [POS_W-1:0]   r_pos_x;
    logic signed [POS_W-1:0]   r_pos_y;
    logic [HEAD_W-1:0]         r_heading;
    logic                      r_out_valid;
    logic [M_DATA_W-1:0]       r_out_data;

    logic                      w_flip;
    logic [15:0]               w_ang;
    logic signed [CW-1:0]      w_xs;
    logic signed [CW-1:0]      w_ys;
    logic signed [CW-1:0]      w_atan;
    logic signed [CW-1:0]      w_tx;
    logic signed [CW-1:0]      w_ty;
    logic signed [31:0]        w_ma;
    logic signed [31:0]        w_mb;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_rx;
    logic signed [PROD_W-1:0]  w_ry;
    logic signed [PROD_W-1:0]  w_rh;
    logic signed [POS_W:0]     w_sum_x;
    logic signed [POS_W:0]     w_sum_y;
    logic signed [POS_W-1:0]   w_sat_x;
    logic signed [POS_W-1:0]   w_sat_y;

    // fold heading into a quarter turn either side of zero
    assign w_flip = r_heading[15] ^ r_heading[14];
    assign w_ang  = {r_heading[15] ^ w_flip, r_heading[14:0]};

    assign w_xs   = r_cx >>> r_step;
    assign w_ys   = r_cy >>> r_step;
    assign w_atan = $signed({4'b0, atan_val(r_step)});

    assign w_tx = r_flip ? -r_cx : r_cx;
    assign w_ty = r_flip ? -r_cy : r_cy;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.mul_op)
            MUL_VDT: begin
                w_ma = 32'(r_spd);
                w_mb = $signed({16'b0, r_step_time});
            end
            MUL_RDT: begin
                w_ma = 32'(r_rate);
                w_mb = $signed({16'b0, r_step_time});
            end
            MUL_TURN: begin
                w_ma = r_rdt;
                w_mb = RAD_TO_BAM;
            end
            MUL_PX: begin
                w_ma = r_vdt;
                w_mb = w_tx[31:0];
            end
            MUL_PY: begin
                w_ma = r_vdt;
                w_mb = w_ty[31:0];
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // round half up and move to the position or angle grid
    assign w_rx = r_px + (64'sd1 <<< 37);
    assign w_ry = r_py + (64'sd1 <<< 37);
    assign w_rh = r_pturn + (64'sd1 <<< 39);

    assign w_sum_x = {r_pos_x[POS_W-1], r_pos_x} + 33'($signed(w_rx[63:38]));
    assign w_sum_y = {r_pos_y[POS_W-1], r_pos_y} + 33'($signed(w_ry[63:38]));

    always_comb begin
        w_sat_x = w_sum_x[POS_W-1:0];
        if (w_sum_x[POS_W] != w_sum_x[POS_W-1]) begin
            w_sat_x = w_sum_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        w_sat_y = w_sum_y[POS_W-1:0];
        if (w_sum_y[POS_W] != w_sum_y[POS_W-1]) begin
            w_sat_y = w_sum_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= STEP_TIME_RESET;
        end else if (i_cfg_we) begin
            r_step_time <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_spd  <= $signed(i_in_data[IN_W-1:0]);
            r_rate <= $signed(i_in_data[2*IN_W-1:IN_W]);
            r_cx   <= CORDIC_GAIN;
            r_cy   <= '0;
            r_cz   <= $signed({{2{w_ang[15]}}, w_ang, 16'b0});
            r_flip <= w_flip;
        end else if (i_cmd.rotate) begin
            if (!r_cz[CW-1]) begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_cz <= r_cz - w_atan;
            end else begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_cz <= r_cz + w_atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.load) begin
            r_step <= '0;
        end else if (i_cmd.rotate) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.mul_op)
            MUL_VDT:  r_vdt   <= w_prod[31:0];
            MUL_RDT:  r_rdt   <= w_prod[31:0];
            MUL_TURN: r_pturn <= w_prod;
            MUL_PX:   r_px    <= w_prod;
            MUL_PY:   r_py    <= w_prod;
            default:  r_pturn <= r_pturn;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= '0;
        end else if (i_cmd.update) begin
            r_pos_x   <= w_sat_x;
            r_pos_y   <= w_sat_y;
            r_heading <= r_heading + w_rh[55:40];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {r_heading, r_pos_y, r_pos_x};
        end
    end

    assign o_sts.rot_last = (r_step == STEP_W'(CORDIC_STEPS - 1));
    assign o_sts.step     = r_step;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: hw/rtl/unicycle_pose_integrator_unit.sv
// top level of the unicycle dead-reckoning pose integrator
// from input transfer to result valid: load, cordic rotations, x and y scaling, pose update, output load
// one item at a time: no new item is taken until the last is handed to the output register
// the output register frees the input side while a result waits to be taken
// reset (synchronous, active low): pose and heading to zero, step_time to 655, channels empty
module unicycle_pose_integrator_unit #(
    parameter int CORDIC_STEPS = upi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // step_time register, unsigned q0.16
    input  logic                          i_cfg_we,
    input  logic [15:0]                   i_cfg_wdata,
    // input item stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] linear_speed, [31:16] turn_rate
    input  logic [upi_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] pose_x, [63:32] pose_y, [79:64] pose_heading
    output logic [upi_pkg::M_DATA_W-1:0]  m_axis_tdata
);
    import upi_pkg::*;

`include "unicycle_pose_integrator_unit_defines.svh"

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // controller: accept, rotate, scale, update, hand over
    upi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: cordic on the old heading, one shared 32x32 multiplier,
    // saturating position update and wrapping heading update
    upi_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    // an input transfer always starts a fresh rotation
    `UPI_ASSERT_NOW(a_xfer_loads, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, w_cmd.load, "input transfer without datapath load")
    // the block is busy right after taking an item
    `UPI_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready stayed high after input transfer")
    // a loaded result is presented on the next cycle
    `UPI_ASSERT_NEXT(a_out_shown, i_clk, i_rst_n, w_cmd.out_load, m_axis_tvalid, "loaded result not presented")
    // the output register is only refilled once free
    `UPI_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, !m_axis_tvalid || m_axis_tready, "pending result overwritten")

endmodule

FILE: sim/tb.sv
// self-checking testbench of the unicycle pose integrator, stream driver and monitor
module tb;

    localparam int     ROTATIONS   = upi_pkg::CORDIC_STEPS_DEF;
    localparam int     ARCTAN_LEN  = 24;
    localparam int     ROT_USED    = (ROTATIONS > ARCTAN_LEN) ? ARCTAN_LEN : ROTATIONS;
    localparam int     LATENCY     = ROTATIONS + 4;
    localparam longint ROT_GAIN    = 64'sd652032874;
    localparam longint TURN_TO_BAM = 64'sd683565276;
    localparam int     LONG_HOLD   = 400;

    // atan(2^-i) in units of 2^-32 turn
    localparam longint ARCTAN_TURN [ARCTAN_LEN] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        hdg;
    } t_pose;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [15:0]                     i_cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // [15:0] linear_speed, [31:16] turn_rate
    logic [upi_pkg::S_DATA_W-1:0]    s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [31:0] pose_x, [63:32] pose_y, [79:64] pose_heading
    logic [upi_pkg::M_DATA_W-1:0]    m_axis_tdata;

    // predicted block state
    logic [15:0]        dt_model;
    logic signed [31:0] x_model;
    logic signed [31:0] y_model;
    logic [15:0]        hdg_model;

    logic [31:0] pending_cmd[$];
    t_pose       expected_pose[$];

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  items_accepted = 0;
    int  sat_hits = 0;
    int  settings_used = 1;
    bit  calm = 1'b0;

    unicycle_pose_integrator_unit #(
        .CORDIC_STEPS (ROTATIONS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one euler step: trig of the old heading, position update, then heading update
    function automatic t_pose advance_pose(input logic signed [15:0] spd,
                                           input logic signed [15:0] rate);
        longint a, x, y, z, xs, ys, vdt, dx, dy, dh, nx, ny;
        logic   flip;
        t_pose  r;
        flip = (hdg_model >= 16'h4000) && (hdg_model < 16'hC000);
        if (flip)
            a = longint'(hdg_model) - 32768;
        else if (hdg_model >= 16'h8000)
            a = longint'(hdg_model) - 65536;
        else
            a = longint'(hdg_model);
        z = a * 65536;
        x = ROT_GAIN;
        y = 0;
        for (int i = 0; i < ROT_USED; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_TURN[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_TURN[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        vdt = longint'(spd) * longint'(dt_model);
        dx = (vdt * x + (longint'(1) <<< 37)) >>> 38;
        dy = (vdt * y + (longint'(1) <<< 37)) >>> 38;
        nx = longint'(x_model) + dx;
        ny = longint'(y_model) + dy;
        if (nx > 64'sd2147483647) begin
            x_model = 32'sh7FFFFFFF;
            sat_hits++;
        end else if (nx < -64'sd2147483648) begin
            x_model = 32'sh80000000;
            sat_hits++;
        end else begin
            x_model = nx[31:0];
        end
        if (ny > 64'sd2147483647) begin
            y_model = 32'sh7FFFFFFF;
            sat_hits++;
        end else if (ny < -64'sd2147483648) begin
            y_model = 32'sh80000000;
            sat_hits++;
        end else begin
            y_model = ny[31:0];
        end
        // radians to binary angle, rounded half up, wraps at a full turn
        dh = (longint'(rate) * longint'(dt_model) * TURN_TO_BAM + (longint'(1) <<< 39)) >>> 40;
        hdg_model = hdg_model + dh[15:0];
        r.x = x_model;
        r.y = y_model;
        r.hdg = hdg_model;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("mismatch on %s at result %0d: got %0d, want %0d",
                 what, results_seen, got, want);
    endtask

    task automatic queue_item(input logic [15:0] spd, input logic [15:0] rate);
        pending_cmd.push_back({rate, spd});
    endtask

    // block is idle once nothing is queued, offered or outstanding
    task automatic wait_quiet();
        @(negedge i_clk);
        while (pending_cmd.size() != 0 || s_axis_tvalid || expected_pose.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic set_step_time(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_used++;
    endtask

    function automatic logic [15:0] pick_field();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'(16'(0) - 16'($urandom_range(1, 255)));
            default: return 16'($urandom);
        endcase
    endfunction

    // driver: predicts on every input transfer, then offers the next queued item
    always @(posedge i_clk) begin : drive_proc
        bit    offering;
        int    gap_left;
        t_pose next_pose;
        if (!i_rst_n) begin
            dt_model = upi_pkg::STEP_TIME_RESET;
            x_model = '0;
            y_model = '0;
            hdg_model = '0;
            gap_left = 0;
            s_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we)
                dt_model = i_cfg_wdata;
            offering = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                next_pose = advance_pose(s_axis_tdata[15:0], s_axis_tdata[31:16]);
                expected_pose.push_back(next_pose);
                items_accepted++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_cmd.size() > 0) begin
                    s_axis_tdata <= pending_cmd.pop_front();
                    offering = 1'b1;
                    // every third block of 40 items runs without sender gaps
                    if (!calm && ((items_accepted / 40) % 3 != 0) && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 18);
                end
            end
            s_axis_tvalid <= offering;
        end
    end

    // monitor: checks each result transfer and shapes the receiver back-pressure
    always @(posedge i_clk) begin : watch_proc
        t_pose want;
        bit    ready_next;
        bit    held_once;
        int    stall_left;
        int    hold_left;
        if (!i_rst_n) begin
            stall_left = 0;
            hold_left = 0;
            held_once = 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_pose.size() == 0) begin
                    report_mismatch("result with nothing pending", 0, 0);
                end else begin
                    want = expected_pose.pop_front();
                    if (m_axis_tdata[31:0] !== want.x)
                        report_mismatch("pose_x", $signed(m_axis_tdata[31:0]), want.x);
                    if (m_axis_tdata[63:32] !== want.y)
                        report_mismatch("pose_y", $signed(m_axis_tdata[63:32]), want.y);
                    if (m_axis_tdata[79:64] !== want.hdg)
                        report_mismatch("pose_heading", m_axis_tdata[79:64], want.hdg);
                end
                // long hold-off while the sender keeps offering, fills the block up
                if (results_seen == 60 && !held_once) begin
                    hold_left = LONG_HOLD;
                    held_once = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
                if (!calm && ((results_seen / 40) % 3 != 1) && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 18);
            end
            m_axis_tready <= ready_next;
        end
    end

    initial begin : stimulus
        logic signed [15:0] h_signed;
        longint             align;
        logic [15:0]        dt_pick;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // field extremes and bit patterns at the reset step time
        queue_item(16'h0000, 16'h0000);
        queue_item(16'h7FFF, 16'h0000);
        queue_item(16'h8000, 16'h0000);
        queue_item(16'h0001, 16'h0000);
        queue_item(16'hFFFF, 16'h0000);
        queue_item(16'h0000, 16'h7FFF);
        queue_item(16'h7FFF, 16'h7FFF);
        queue_item(16'h8000, 16'h8000);
        queue_item(16'h0000, 16'h8000);
        queue_item(16'h5555, 16'hAAAA);
        queue_item(16'hAAAA, 16'h5555);
        queue_item(16'h0100, 16'h0100);
        queue_item(16'hFF00, 16'hFF00);
        queue_item(16'h7FFF, 16'hFFFF);
        queue_item(16'hFFFF, 16'h0001);
        queue_item(16'h8000, 16'h7FFF);
        wait_quiet();

        // zero step time leaves the pose untouched
        set_step_time(16'h0000);
        queue_item(16'h7FFF, 16'h7FFF);
        queue_item(16'h8000, 16'h8000);
        queue_item(16'h3039, 16'hA460);
        queue_item(16'hFFFF, 16'h0001);
        wait_quiet();

        // full-scale step: turn back near heading zero, drive x into the upper clamp,
        // then a quarter turn and reverse speed drive y into the lower clamp
        set_step_time(16'hFFFF);
        h_signed = hdg_model;
        align = -((longint'(h_signed) * (longint'(1) <<< 40)) / (longint'(65535) * TURN_TO_BAM));
        queue_item(16'h0000, 16'(align));
        for (int i = 0; i < 300; i++)
            queue_item(16'(32767 - $urandom_range(0, 255)), 16'h0000);
        queue_item(16'h0000, 16'd402);
        for (int i = 0; i < 300; i++)
            queue_item(16'(16'h8000 + $urandom_range(0, 255)), 16'h0000);
        wait_quiet();

        // random items over several step times, the last part without idling
        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       dt_pick = 16'($urandom_range(1, 65535));
                1:       dt_pick = 16'h8000;
                2:       dt_pick = 16'h0001;
                3:       dt_pick = 16'($urandom_range(2, 1000));
                default: dt_pick = upi_pkg::STEP_TIME_RESET;
            endcase
            set_step_time(dt_pick);
            if (p == 4)
                calm = 1'b1;
            for (int i = 0; i < 150; i++)
                queue_item(pick_field(), pick_field());
            wait_quiet();
        end

        $display("covered %0d input transfers and %0d results over %0d step-time settings",
                 items_accepted, results_seen, settings_used);
        $display("zero and full-scale step included, positions clamped in %0d updates",
                 sat_hits);
        if (mismatch_count == 0 && expected_pose.size() == 0)
            $display("unicycle_pose_integrator_unit test passed");
        else
            $display("unicycle_pose_integrator_unit test failed");
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("unicycle_pose_integrator_unit test failed");
        $finish;
    end

endmodule
